>>> rtl/ppmfd_pkg.sv
// Package with the shared types, codes and constants of the PPM frame decoder.
`timescale 1ns / 1ps

package ppmfd_pkg;

  localparam int CHANNELS_DEF = 32;
  localparam int WIDTH_W      = 16;
  localparam int PCT_W        = 7;
  localparam int CNT_W        = 6;
  localparam int IDX_W        = 5;
  localparam int TOTAL_W      = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int DIV_W        = WIDTH_W + PCT_W;

  localparam logic [WIDTH_W-1:0] SYNC_MIN_RST    = 16'd2500;
  localparam logic [WIDTH_W-1:0] CHAN_GAP_RST    = 16'd300;
  localparam logic [WIDTH_W-1:0] CHAN_MIN_RST    = 16'd700;
  localparam logic [WIDTH_W-1:0] CHAN_MAX_RST    = 16'd1700;
  localparam logic [CNT_W-1:0]   FRAME_COUNT_RST = 6'd7;
  localparam logic [PCT_W-1:0]   PERCENT_FULL    = 7'd100;

  typedef enum logic [1:0] {
    FUNC_PULSE   = 2'd0,
    FUNC_TIMEOUT = 2'd1,
    FUNC_READ    = 2'd2,
    FUNC_NOP     = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_MIN    = 3'd0,
    REG_CHAN_GAP    = 3'd1,
    REG_CHAN_MIN    = 3'd2,
    REG_CHAN_MAX    = 3'd3,
    REG_FRAME_COUNT = 3'd4
  } reg_e;

  typedef struct packed {
    func_e              func;
    logic [WIDTH_W-1:0] pulse_ticks;
    logic [IDX_W-1:0]   channel_index;
  } item_t;

  typedef struct packed {
    logic               link_status;
    logic [TOTAL_W-1:0] packet_count;
    logic [WIDTH_W-1:0] channel_raw;
    logic [PCT_W-1:0]   channel_percent;
    logic               frame_done;
    logic               fault;
  } result_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic rd;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic needs_div;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/ppmfd_if.sv
// Channel interfaces of the PPM frame decoder: input items, results and configuration writes.
`timescale 1ns / 1ps

interface ppmfd_in_if;
  import ppmfd_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [WIDTH_W-1:0] pulse_ticks;
  logic [IDX_W-1:0]   channel_index;

  modport source (output valid, func, pulse_ticks, channel_index, input ready);
  modport sink (input valid, func, pulse_ticks, channel_index, output ready);
endinterface

interface ppmfd_out_if;
  import ppmfd_pkg::*;
  logic               valid;
  logic               ready;
  logic               link_status;
  logic [TOTAL_W-1:0] packet_count;
  logic [WIDTH_W-1:0] channel_raw;
  logic [PCT_W-1:0]   channel_percent;
  logic               frame_done;
  logic               fault;

  modport source (output valid, link_status, packet_count, channel_raw, channel_percent,
                  frame_done, fault, input ready);
  modport sink (input valid, link_status, packet_count, channel_raw, channel_percent,
                frame_done, fault, output ready);
endinterface

interface ppmfd_cfg_if;
  import ppmfd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/ppm_frame_decoder_unit.sv
// Top level of the PPM frame decoder: controller, datapath and channel interfaces.
// Each accepted item is decoded and then committed to the result register once the output
// is free; a channel pulse whose percent lies strictly inside the span first passes the
// 7-step divider. One item is in flight: the next is accepted only after the commit.
// Reset: asynchronous, active low; configuration returns to its defaults, the link
// reads lost, and the channel store reads zero through per-entry valid bits (no sweep).
`timescale 1ns / 1ps

module ppm_frame_decoder_unit #(
  parameter int CHANNELS = ppmfd_pkg::CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ppmfd_in_if.sink    in_if,
  ppmfd_out_if.source out_if,
  ppmfd_cfg_if.sink   cfg_if
);
  import ppmfd_pkg::*;

  item_t      item;
  result_t    result;
  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;

  assign item.func          = func_e'(in_if.func);
  assign item.pulse_ticks   = in_if.pulse_ticks;
  assign item.channel_index = in_if.channel_index;
  assign in_if.ready        = in_ready;
  assign cfg_if.ready       = 1'b1;

  ppmfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ppmfd_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_valid_i (cfg_if.valid),
    .cfg_index_i (cfg_if.index),
    .cfg_data_i  (cfg_if.data),
    .result_o    (result),
    .out_valid_o (out_valid),
    .out_ready_i (out_if.ready)
  );

  assign out_if.valid           = out_valid;
  assign out_if.link_status     = result.link_status;
  assign out_if.packet_count    = result.packet_count;
  assign out_if.channel_raw     = result.channel_raw;
  assign out_if.channel_percent = result.channel_percent;
  assign out_if.frame_done      = result.frame_done;
  assign out_if.fault           = result.fault;

endmodule

>>> rtl/ppmfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ppmfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ppmfd_ctrl.sv
// Controller state machine that sequences decode, percent division and result commit.
`timescale 1ns / 1ps

module ppmfd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ppmfd_pkg::dp_status_t status_i,
  output ppmfd_pkg::ctrl_cmd_t  cmd_o
);
  import ppmfd_pkg::*;

  localparam int STEP_W = $clog2(PCT_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_COMMIT
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] step_q;
  logic              in_ready_q;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.load = in_valid_i && in_ready_q;
      end
      S_DECODE: begin
        cmd_o.rd  = status_i.is_read;
        cmd_o.mul = status_i.needs_div;
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
      end
      S_COMMIT: begin
        cmd_o.commit = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      step_q     <= '0;
      in_ready_q <= 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_q) begin
            state_q    <= S_DECODE;
            in_ready_q <= 1'b0;
          end
        end
        S_DECODE: begin
          if (status_i.needs_div) begin
            state_q <= S_DIV;
            step_q  <= STEP_W'(PCT_W - 1);
          end else begin
            state_q <= S_COMMIT;
          end
        end
        S_DIV: begin
          if (step_q == '0) begin
            state_q <= S_COMMIT;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        S_COMMIT: begin
          if (status_i.out_free) begin
            state_q    <= S_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= S_IDLE;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready_o = in_ready_q;

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_q |-> state_q == S_IDLE)
    else $error("input ready outside the idle state");

  a_div_from_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == S_DIV) |-> $past(state_q) == S_DECODE && $past(status_i.needs_div))
    else $error("division entered without a request");

  a_commit_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> !cmd_o.commit)
    else $error("two commits in a row");

endmodule

>>> rtl/ppmfd_datapath.sv
// Datapath: configuration, frame state, channel store, percent divider and result register.
`timescale 1ns / 1ps

module ppmfd_datapath #(
  parameter int CHANNELS = ppmfd_pkg::CHANNELS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ppmfd_pkg::item_t                     item_i,
  input  ppmfd_pkg::ctrl_cmd_t                 cmd_i,
  output ppmfd_pkg::dp_status_t                status_o,
  input  logic                                 cfg_valid_i,
  input  logic [ppmfd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ppmfd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output ppmfd_pkg::result_t                   result_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i
);
  import ppmfd_pkg::*;

  localparam int AW    = $clog2(CHANNELS);
  localparam int RAM_W = WIDTH_W + PCT_W;
  localparam logic [CNT_W-1:0] CHAN_N = CNT_W'(CHANNELS);

  logic [WIDTH_W-1:0] sync_q, gap_q, lo_q, hi_q;
  logic [CNT_W-1:0]   fcc_q;

  item_t              item_q;
  logic               in_frame_q, in_frame_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               lost_q, lost_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [CHANNELS-1:0] valid_q;

  logic [DIV_W-1:0]   rem_q, den_q;
  logic [PCT_W-1:0]   quo_q;

  result_t            out_q, out_d;
  logic               out_valid_q;

  logic [WIDTH_W-1:0] width, raw, diff, span;
  logic               span_pos, store_case, frame_end, idx_ok, rd_hit, out_free;
  logic [PCT_W-1:0]   pct;
  logic [CNT_W-1:0]   eff_n, cnt_inc;
  logic [AW-1:0]      rd_idx, slot;
  logic [RAM_W-1:0]   ram_rdata;

  assign width    = item_q.pulse_ticks;
  assign raw      = (width > gap_q) ? width - gap_q : '0;
  assign span_pos = hi_q > lo_q;
  assign diff     = raw - lo_q;
  assign span     = hi_q - lo_q;

  always_comb begin
    if (!span_pos || raw <= lo_q) begin
      pct = '0;
    end else if (raw >= hi_q) begin
      pct = PERCENT_FULL;
    end else begin
      pct = quo_q;
    end
  end

  always_comb begin
    if (fcc_q == '0) begin
      eff_n = CNT_W'(1);
    end else if (fcc_q > CHAN_N) begin
      eff_n = CHAN_N;
    end else begin
      eff_n = fcc_q;
    end
  end

  assign store_case = (item_q.func == FUNC_PULSE) && in_frame_q && (width < sync_q);
  assign cnt_inc    = cnt_q + 1'b1;
  assign frame_end  = store_case && (cnt_inc >= eff_n);
  assign slot       = cnt_q[AW-1:0];
  assign rd_idx     = item_q.channel_index[AW-1:0];
  assign idx_ok     = {1'b0, item_q.channel_index} < CHAN_N;
  assign rd_hit     = idx_ok && valid_q[rd_idx];
  assign out_free   = !out_valid_q || out_ready_i;

  assign status_o.is_read   = item_q.func == FUNC_READ;
  assign status_o.needs_div = store_case && span_pos && (raw > lo_q) && (raw < hi_q);
  assign status_o.out_free  = out_free;

  ppmfd_ram #(
    .WIDTH (RAM_W),
    .DEPTH (CHANNELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && store_case),
    .waddr_i (slot),
    .wdata_i ({raw, pct}),
    .re_i    (cmd_i.rd),
    .raddr_i (rd_idx),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    in_frame_d = in_frame_q;
    cnt_d      = cnt_q;
    lost_d     = lost_q;
    total_d    = total_q;
    out_d      = '0;
    case (item_q.func)
      FUNC_PULSE: begin
        if (!in_frame_q) begin
          if (width > sync_q) begin
            in_frame_d = 1'b1;
            cnt_d      = '0;
          end
        end else if (store_case) begin
          cnt_d = cnt_inc;
          if (frame_end) begin
            lost_d           = 1'b0;
            in_frame_d       = 1'b0;
            total_d          = total_q + 1'b1;
            out_d.frame_done = 1'b1;
          end
        end else begin
          lost_d      = 1'b1;
          in_frame_d  = 1'b0;
          out_d.fault = 1'b1;
        end
      end
      FUNC_TIMEOUT: begin
        in_frame_d  = 1'b0;
        lost_d      = 1'b1;
        out_d.fault = 1'b1;
      end
      FUNC_READ: begin
        if (rd_hit) begin
          out_d.channel_raw     = ram_rdata[RAM_W-1:PCT_W];
          out_d.channel_percent = ram_rdata[PCT_W-1:0];
        end
      end
      default: begin
      end
    endcase
    out_d.link_status  = lost_d;
    out_d.packet_count = total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q      <= SYNC_MIN_RST;
      gap_q       <= CHAN_GAP_RST;
      lo_q        <= CHAN_MIN_RST;
      hi_q        <= CHAN_MAX_RST;
      fcc_q       <= FRAME_COUNT_RST;
      in_frame_q  <= 1'b0;
      cnt_q       <= '0;
      lost_q      <= 1'b1;
      total_q     <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (reg_e'(cfg_index_i))
          REG_SYNC_MIN:    sync_q <= cfg_data_i;
          REG_CHAN_GAP:    gap_q  <= cfg_data_i;
          REG_CHAN_MIN:    lo_q   <= cfg_data_i;
          REG_CHAN_MAX:    hi_q   <= cfg_data_i;
          REG_FRAME_COUNT: fcc_q  <= cfg_data_i[CNT_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.commit) begin
        in_frame_q  <= in_frame_d;
        cnt_q       <= cnt_d;
        lost_q      <= lost_d;
        total_q     <= total_d;
        out_valid_q <= 1'b1;
        if (store_case) begin
          valid_q[slot] <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
    if (cmd_i.mul) begin
      rem_q <= {{PCT_W{1'b0}}, diff} * {{WIDTH_W{1'b0}}, PERCENT_FULL};
      den_q <= {1'b0, span, {(PCT_W - 1){1'b0}}};
      quo_q <= '0;
    end else if (cmd_i.step) begin
      if (rem_q >= den_q) begin
        rem_q <= rem_q - den_q;
        quo_q <= {quo_q[PCT_W-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[PCT_W-2:0], 1'b0};
      end
      den_q <= den_q >> 1;
    end
  end

  assign result_o    = out_q;
  assign out_valid_o = out_valid_q;

  a_commit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> out_free)
    else $error("result committed over a waiting result");

  a_percent_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.channel_percent <= PERCENT_FULL)
    else $error("percent above full scale");

  a_fault_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.fault |-> out_q.link_status && !out_q.frame_done)
    else $error("fault beat without lost status");

  a_done_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && frame_end |=> total_q == $past(total_q) + 1'b1 && !lost_q)
    else $error("completed frame not counted");

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the PPM frame decoder: frames, faults, reads and register settings.
`timescale 1ns / 1ps

module testbench;
  import ppmfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int HOLD_CYCLES    = 300;

  logic clk_i = 1'b0;
  logic rst_ni;

  ppmfd_in_if  in_if ();
  ppmfd_out_if out_if ();
  ppmfd_cfg_if cfg_if ();

  ppm_frame_decoder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // Decoder shadow: configuration copy, frame state and channel store.
  logic [15:0] sync_min;
  logic [15:0] gap_w;
  logic [15:0] min_w;
  logic [15:0] max_w;
  logic [5:0]  count_cfg;
  logic        in_frame;
  logic [5:0]  chan_cnt;
  logic        lost;
  logic [31:0] frames;
  logic [15:0] raw_mem [32];
  logic [6:0]  pct_mem [32];

  result_t expected_q [$];
  int      mismatches  = 0;
  int      items_sent  = 0;
  int      tx_idle_max = 17;
  int      rx_idle_max = 17;
  bit      hold_req    = 1'b0;
  int      idle_cycles = 0;

  function automatic void reset_decoder_shadow();
    sync_min  = SYNC_MIN_RST;
    gap_w     = CHAN_GAP_RST;
    min_w     = CHAN_MIN_RST;
    max_w     = CHAN_MAX_RST;
    count_cfg = FRAME_COUNT_RST;
    in_frame  = 1'b0;
    chan_cnt  = '0;
    lost      = 1'b1;
    frames    = '0;
    for (int i = 0; i < 32; i++) begin
      raw_mem[i] = '0;
      pct_mem[i] = '0;
    end
  endfunction

  function automatic logic [6:0] percent_of(logic [15:0] raw);
    logic [31:0] num;
    logic [31:0] den;
    if (max_w <= min_w) return '0;
    if (raw <= min_w) return '0;
    if (raw >= max_w) return PERCENT_FULL;
    num = (32'(raw) - 32'(min_w)) * 32'd100;
    den = 32'(max_w) - 32'(min_w);
    return 7'(num / den);
  endfunction

  function automatic int frame_len();
    int n;
    n = int'(count_cfg);
    if (n == 0) n = 1;
    if (n > CHANNELS_DEF) n = CHANNELS_DEF;
    return n;
  endfunction

  function automatic result_t decode_item(item_t it);
    result_t     r;
    logic [15:0] raw;
    logic [4:0]  slot;
    r = '0;
    case (it.func)
      FUNC_PULSE: begin
        if (!in_frame) begin
          if (it.pulse_ticks > sync_min) begin
            in_frame = 1'b1;
            chan_cnt = '0;
          end
        end else if (it.pulse_ticks < sync_min) begin
          raw = (it.pulse_ticks > gap_w) ? it.pulse_ticks - gap_w : '0;
          slot = chan_cnt[4:0];
          raw_mem[slot] = raw;
          pct_mem[slot] = percent_of(raw);
          chan_cnt = chan_cnt + 6'd1;
          if (int'(chan_cnt) >= frame_len()) begin
            lost = 1'b0;
            in_frame = 1'b0;
            frames = frames + 32'd1;
            r.frame_done = 1'b1;
          end
        end else begin
          lost = 1'b1;
          in_frame = 1'b0;
          r.fault = 1'b1;
        end
      end
      FUNC_TIMEOUT: begin
        in_frame = 1'b0;
        lost = 1'b1;
        r.fault = 1'b1;
      end
      FUNC_READ: begin
        r.channel_raw = raw_mem[it.channel_index];
        r.channel_percent = pct_mem[it.channel_index];
      end
      default: begin
      end
    endcase
    r.link_status = lost;
    r.packet_count = frames;
    return r;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic int pick_idle();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      default: return 17;
    endcase
  endfunction

  function automatic logic [15:0] sync_pulse();
    if (sync_min == 16'hFFFF) return 16'hFFFF;
    return 16'($urandom_range(int'(sync_min) + 1, 65535));
  endfunction

  function automatic logic [15:0] long_pulse();
    return 16'($urandom_range(int'(sync_min), 65535));
  endfunction

  function automatic logic [15:0] channel_pulse();
    int lo;
    int hi;
    int w;
    if (sync_min == 16'd0) return '0;
    if ($urandom_range(0, 3) == 0) begin
      w = $urandom_range(0, int'(sync_min) - 1);
    end else begin
      lo = int'(min_w) - 40;
      if (lo < 0) lo = 0;
      hi = (max_w >= min_w) ? int'(max_w) + 40 : lo + 400;
      w = $urandom_range(lo, hi) + int'(gap_w);
      if (w > 65535) w = 65535;
      if (w >= int'(sync_min)) w = $urandom_range(0, int'(sync_min) - 1);
    end
    return 16'(w);
  endfunction

  task automatic send_item(func_e f, logic [15:0] w, logic [4:0] idx);
    int    gap;
    item_t it;
    gap = (tx_idle_max > 0) ? $urandom_range(0, tx_idle_max) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.func          <= f;
    in_if.pulse_ticks   <= w;
    in_if.channel_index <= idx;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    it.func = f;
    it.pulse_ticks = w;
    it.channel_index = idx;
    expected_q.push_back(decode_item(it));
    items_sent++;
  endtask

  task automatic send_read(logic [4:0] idx);
    send_item(FUNC_READ, 16'($urandom()), idx);
  endtask

  task automatic stop_sending();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [15:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    case (idx)
      REG_SYNC_MIN:    sync_min = data;
      REG_CHAN_GAP:    gap_w = data;
      REG_CHAN_MIN:    min_w = data;
      REG_CHAN_MAX:    max_w = data;
      REG_FRAME_COUNT: count_cfg = data[5:0];
      default: begin
      end
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_config(logic [15:0] s, logic [15:0] g, logic [15:0] lo,
                              logic [15:0] hi, logic [15:0] cnt);
    stop_sending();
    wait_idle();
    write_reg(REG_SYNC_MIN, s);
    write_reg(REG_CHAN_GAP, g);
    write_reg(REG_CHAN_MIN, lo);
    write_reg(REG_CHAN_MAX, hi);
    write_reg(REG_FRAME_COUNT, cnt);
  endtask

  task automatic run_traffic(int n);
    int start;
    int kind;
    int nch;
    start = items_sent;
    while (items_sent - start < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        send_item(FUNC_PULSE, sync_pulse(), 5'($urandom()));
        nch = ($urandom_range(0, 4) == 0) ? $urandom_range(1, frame_len()) : frame_len();
        for (int k = 0; k < nch; k++) begin
          if ($urandom_range(0, 9) == 0) send_read(5'($urandom()));
          send_item(FUNC_PULSE, channel_pulse(), 5'($urandom()));
        end
        repeat ($urandom_range(0, 2)) send_read(5'($urandom()));
      end else if (kind < 80) begin
        repeat ($urandom_range(1, 4)) send_read(5'($urandom()));
      end else if (kind < 88) begin
        send_item(FUNC_PULSE, sync_pulse(), 5'($urandom()));
        repeat ($urandom_range(0, frame_len() - 1)) begin
          send_item(FUNC_PULSE, channel_pulse(), 5'($urandom()));
        end
        if ($urandom_range(0, 1) == 0) begin
          send_item(FUNC_PULSE, long_pulse(), 5'($urandom()));
        end else begin
          send_item(FUNC_TIMEOUT, 16'($urandom()), 5'($urandom()));
        end
      end else begin
        send_item(func_e'($urandom_range(0, 3)), 16'($urandom()), 5'($urandom()));
      end
    end
  endtask

  task automatic test_reset_state();
    send_read(5'd0);
    send_read(5'd31);
    send_item(FUNC_NOP, 16'hFFFF, 5'h1F);
    send_item(FUNC_TIMEOUT, 16'h0000, 5'h00);
  endtask

  task automatic test_directed_frame();
    // A width equal to the sync threshold is ignored while idle.
    send_item(FUNC_PULSE, 16'd2500, 5'd0);
    send_item(FUNC_PULSE, 16'hFFFF, 5'd0);
    send_item(FUNC_PULSE, 16'd0, 5'd0);
    send_item(FUNC_PULSE, 16'd1000, 5'd0);
    send_item(FUNC_PULSE, 16'd2000, 5'd0);
    send_item(FUNC_PULSE, 16'd1500, 5'd0);
    send_item(FUNC_PULSE, 16'd2499, 5'd0);
    send_item(FUNC_PULSE, 16'd1001, 5'd0);
    send_item(FUNC_PULSE, 16'd1999, 5'd0);
    for (int i = 0; i < 7; i++) send_read(5'(i));
    // A width equal to the sync threshold in mid-frame loses the packet.
    send_item(FUNC_PULSE, 16'd2501, 5'd0);
    send_item(FUNC_PULSE, 16'd1300, 5'd0);
    send_item(FUNC_PULSE, 16'd2500, 5'd0);
    send_read(5'd0);
    send_item(FUNC_NOP, 16'h0000, 5'h00);
  endtask

  task automatic test_config_extremes();
    apply_config(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFC1);
    run_traffic(30);
    apply_config(16'hFFFE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0020);
    run_traffic(30);
    apply_config(16'hFFFF, 16'd300, 16'd700, 16'd1700, 16'hFFC0);
    run_traffic(30);
    apply_config(16'd3000, 16'd0, 16'd0, 16'hFFFF, 16'h003F);
    run_traffic(30);
    apply_config(16'd2500, 16'd300, 16'd1700, 16'd700, 16'h0000);
    run_traffic(30);
    apply_config(16'd2500, 16'd300, 16'd1000, 16'd1000, 16'h0007);
    run_traffic(30);
    apply_config(16'd60000, 16'd0, 16'd1, 16'd2, 16'h5A21);
    run_traffic(30);
  endtask

  task automatic test_backpressure();
    apply_config(16'd2500, 16'd300, 16'd700, 16'd1700, 16'h0004);
    tx_idle_max = 0;
    hold_req = 1'b1;
    run_traffic(40);
    tx_idle_max = 17;
  endtask

  task automatic test_random_traffic();
    logic [15:0] s;
    logic [15:0] g;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] cnt;
    for (int phase = 0; phase < 8; phase++) begin
      if ($urandom_range(0, 3) == 0) begin
        s = 16'($urandom());
        g = 16'($urandom());
        lo = 16'($urandom());
        hi = 16'($urandom());
        cnt = 16'($urandom());
      end else begin
        s = 16'($urandom_range(1500, 4000));
        g = 16'($urandom_range(0, 500));
        lo = 16'($urandom_range(0, 1000));
        hi = lo + 16'($urandom_range(0, 1500));
        cnt = {10'($urandom()), 6'($urandom_range(0, 40))};
      end
      apply_config(s, g, lo, hi, cnt);
      tx_idle_max = pick_idle();
      rx_idle_max = pick_idle();
      run_traffic(80);
    end
  endtask

  initial begin
    rst_ni              <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.func          <= FUNC_NOP;
    in_if.pulse_ticks   <= '0;
    in_if.channel_index <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= REG_SYNC_MIN;
    cfg_if.data         <= '0;
    reset_decoder_shadow();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed_frame();
    test_config_extremes();
    test_backpressure();
    test_random_traffic();
    stop_sending();
    wait_idle();
    if (mismatches == 0) begin
      $display("ppm_frame_decoder_unit test passed");
    end else begin
      $display("ppm_frame_decoder_unit test failed");
    end
    $finish;
  end

  initial begin
    int      stall;
    result_t want;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = (rx_idle_max > 0) ? $urandom_range(0, rx_idle_max) : 0;
      if (hold_req) begin
        stall = stall + HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with no expectation waiting, expected none, actual count %0d",
                 $time, out_if.packet_count);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        compare_field("link_status", want.link_status, out_if.link_status);
        compare_field("packet_count", want.packet_count, out_if.packet_count);
        compare_field("channel_raw", want.channel_raw, out_if.channel_raw);
        compare_field("channel_percent", want.channel_percent, out_if.channel_percent);
        compare_field("frame_done", want.frame_done, out_if.frame_done);
        compare_field("fault", want.fault, out_if.fault);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("ppm_frame_decoder_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
